@@ src/pkbd_pkg.sv @@
`timescale 1ns / 1ps

package pkbd_pkg;

    localparam logic [1:0] ACT_DATA  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    localparam logic [7:0] LIT_MAX_HDR = 8'd127;
    localparam logic [7:0] NOP_HDR     = 8'd128;
    localparam logic [8:0] RUN_BASE    = 9'd257;

    localparam int CMD_DEPTH = 4;

    localparam logic [15:0] REQ_LEN_RESET = 16'd40;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  byte_count;
        logic        last;
        logic        done_res;
        logic [15:0] produced;
    } result_t;

    // one decoded run (or a bare done mark when len is zero)
    typedef struct packed {
        logic [7:0]  value;
        logic [7:0]  len;
        logic        done;
        logic [15:0] base;
    } cmd_t;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_HEADER  = 6'b000010,
        PH_LITERAL = 6'b000100,
        PH_REPVAL  = 6'b001000,
        PH_SKIP    = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

endpackage

@@ src/pkbd_front.sv @@
`timescale 1ns / 1ps

module pkbd_front
    import pkbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        accept,
    input  item_t       item,
    output logic        cmd_valid,
    output cmd_t        cmd
);

    logic [15:0] req_len_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  lit_reg, lit_next;
    logic [7:0]  skip_reg, skip_next;
    logic [15:0] budget_reg, budget_next;
    logic [15:0] prod_reg, prod_next;

    always_comb
    begin
        logic        active;
        logic [7:0]  len;
        logic [7:0]  rem;
        phase_t      fin;

        phase_next  = phase_reg;
        lit_next    = lit_reg;
        skip_next   = skip_reg;
        budget_next = budget_reg;
        prod_next   = prod_reg;
        cmd_valid   = 1'b0;
        cmd.value   = item.data_byte;
        cmd.len     = '0;
        cmd.done    = 1'b0;
        cmd.base    = prod_reg;
        len         = item.data_byte + 8'd1;
        rem         = '0;
        fin         = phase_reg;
        active      = (phase_reg == PH_HEADER) || (phase_reg == PH_LITERAL)
                   || (phase_reg == PH_REPVAL) || (phase_reg == PH_SKIP);

        if (accept)
        begin
            unique case (item.action)
                ACT_START:
                begin
                    budget_next = req_len_reg;
                    prod_next   = '0;
                    lit_next    = '0;
                    skip_next   = '0;
                    if (req_len_reg == '0)
                    begin
                        phase_next = PH_DONE;
                        cmd_valid  = 1'b1;
                        cmd.done   = 1'b1;
                        cmd.base   = '0;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                ACT_END:
                begin
                    if (active)
                    begin
                        phase_next = PH_DONE;
                        lit_next   = '0;
                        skip_next  = '0;
                        cmd_valid  = 1'b1;
                        cmd.done   = 1'b1;
                    end
                end
                ACT_DATA:
                begin
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            if (item.data_byte <= LIT_MAX_HDR)
                            begin
                                lit_next   = ({8'd0, len} < budget_reg) ? len
                                                                        : budget_reg[7:0];
                                skip_next  = len - lit_next;
                                phase_next = (lit_next != '0) ? PH_LITERAL : PH_SKIP;
                            end
                            else if (item.data_byte != NOP_HDR)
                            begin
                                lit_next   = 8'(RUN_BASE - {1'b0, item.data_byte});
                                phase_next = PH_REPVAL;
                            end
                        end
                        PH_LITERAL:
                        begin
                            lit_next    = lit_reg - 8'd1;
                            budget_next = budget_reg - 16'd1;
                            prod_next   = prod_reg + 16'd1;
                            if (skip_reg != '0)
                                fin = PH_SKIP;
                            else if (budget_next == '0)
                                fin = PH_DONE;
                            else
                                fin = PH_HEADER;
                            if (lit_next == '0)
                                phase_next = fin;
                            cmd_valid = 1'b1;
                            cmd.len   = 8'd1;
                            cmd.done  = (phase_next == PH_DONE);
                        end
                        PH_REPVAL:
                        begin
                            rem         = ({8'd0, lit_reg} < budget_reg) ? lit_reg
                                                                         : budget_reg[7:0];
                            lit_next    = '0;
                            budget_next = budget_reg - {8'd0, rem};
                            prod_next   = prod_reg + {8'd0, rem};
                            phase_next  = (budget_next == '0) ? PH_DONE : PH_HEADER;
                            cmd_valid   = 1'b1;
                            cmd.len     = rem;
                            cmd.done    = (budget_next == '0);
                        end
                        PH_SKIP:
                        begin
                            skip_next = skip_reg - 8'd1;
                            if (skip_next == '0)
                            begin
                                if (budget_reg == '0)
                                begin
                                    phase_next = PH_DONE;
                                    cmd_valid  = 1'b1;
                                    cmd.done   = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_HEADER;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_len_reg <= REQ_LEN_RESET;
            phase_reg   <= PH_IDLE;
            lit_reg     <= '0;
            skip_reg    <= '0;
            budget_reg  <= '0;
            prod_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                req_len_reg <= cfg_wdata;
            phase_reg  <= phase_next;
            lit_reg    <= lit_next;
            skip_reg   <= skip_next;
            budget_reg <= budget_next;
            prod_reg   <= prod_next;
        end
    end

endmodule

@@ src/pkbd_cmd_fifo.sv @@
`timescale 1ns / 1ps

module pkbd_cmd_fifo
    import pkbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic full,
    output logic not_empty
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             store_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_W'(1);
        else if (!wr_en && rd_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/pkbd_back.sv @@
`timescale 1ns / 1ps

module pkbd_back
    import pkbd_pkg::*;
#(
    parameter int LANE_BYTES = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_avail,
    input  cmd_t    cmd,
    output logic    cmd_take,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    localparam logic [7:0] LANE_W = 8'(LANE_BYTES);

    logic       started_reg, started_next;
    logic [7:0] rem_reg, rem_next;
    logic [15:0] prod_reg, prod_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    always_comb
    begin
        logic [7:0]  rem;
        logic [15:0] prod;
        logic [7:0]  cnt;
        logic        fire;

        rem  = started_reg ? rem_reg : cmd.len;
        prod = started_reg ? prod_reg : cmd.base;
        cnt  = (rem < LANE_W) ? rem : LANE_W;
        fire = cmd_avail && (!out_valid_reg || pop);

        started_next   = started_reg;
        rem_next       = rem_reg;
        prod_next      = prod_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        cmd_take       = 1'b0;

        if (fire)
        begin
            for (int i = 0; i < 8; i++)
                out_next.data[8*i +: 8] = (8'(i) < cnt) ? cmd.value : 8'd0;
            out_next.byte_count = 4'(cnt);
            out_next.last       = (rem == cnt);
            out_next.done_res   = cmd.done && (rem == cnt);
            out_next.produced   = prod + {8'd0, cnt};
            out_valid_next      = 1'b1;
            rem_next            = rem - cnt;
            prod_next           = prod + {8'd0, cnt};
            if (rem == cnt)
            begin
                started_next = 1'b0;
                cmd_take     = 1'b1;
            end
            else
            begin
                started_next = 1'b1;
            end
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        rem_reg  <= rem_next;
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/packbits_run_length_decoder.sv @@
`timescale 1ns / 1ps
// PackBits decoder. One input transaction is taken per cycle while the run queue has room.
// A run of n bytes leaves as ceil(n / LANE_BYTES) result transactions, set by the lane expander,
// one per cycle while results are popped; a literal, skip or done mark gives at most one.
// An input reaches its first result through the queue write, then the result register.
// rst_n is asynchronous, active low: idle phase, empty queue, request_length = 40.
module packbits_run_length_decoder
    import pkbd_pkg::*;
#(
    parameter int LANE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  item_t       item,
    output logic        empty,
    input  logic        pop,
    output result_t     result
);

    logic accept;
    logic cmd_valid;
    cmd_t cmd_in;
    cmd_t cmd_head;
    logic cmd_avail;
    logic cmd_take;

    assign accept = push && !full;

    pkbd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_in)
    );

    pkbd_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_valid),
        .wr_data   (cmd_in),
        .rd_en     (cmd_take),
        .rd_data   (cmd_head),
        .full      (full),
        .not_empty (cmd_avail)
    );

    pkbd_back #(
        .LANE_BYTES (LANE_BYTES)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd       (cmd_head),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

@@ test/packbits_run_length_decoder_tb.sv @@
`timescale 1ns / 1ps

module packbits_run_length_decoder_tb;
    import pkbd_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int LANES = 8;
    localparam int RANDOM_ITEMS = 90;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 50000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        push;
    logic        full;
    item_t       item;
    logic        empty;
    logic        pop;
    result_t     result;

    // decoder state as predicted
    logic [15:0] req_len;
    phase_t      ph;
    logic [7:0]  lit_left;
    logic [7:0]  skip_left;
    logic [15:0] budget_left;
    logic [15:0] produced_cnt;

    result_t     due_results[$];
    result_t     head;
    int          mismatches;
    int          decoded_items;
    bit          tx_gaps;
    bit          rx_stalls;
    int          stall_left;

    packbits_run_length_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic result_t make_result(logic [63:0] d, logic [3:0] c, logic dn);
        result_t r;
        r.data       = d;
        r.byte_count = c;
        r.last       = 1'b0;
        r.done_res   = dn;
        r.produced   = produced_cnt;
        return r;
    endfunction

    function automatic bit stream_open();
        return ph == PH_HEADER || ph == PH_LITERAL || ph == PH_REPVAL || ph == PH_SKIP;
    endfunction

    function automatic void end_of_copy();
        if (skip_left != 8'd0)
            ph = PH_SKIP;
        else if (budget_left == 16'd0)
            ph = PH_DONE;
        else
            ph = PH_HEADER;
    endfunction

    // returns 1 if the transaction was not ignored by the decoder
    function automatic bit decode_item(item_t it);
        result_t     burst[$];
        logic [8:0]  copy_len;
        logic [15:0] rem;
        logic [3:0]  c;
        logic [63:0] d;
        logic [7:0]  b;
        bit          used;
        b = it.data_byte;
        used = 1'b0;
        if (it.action == ACT_START)
        begin
            used = 1'b1;
            budget_left  = req_len;
            produced_cnt = 16'd0;
            lit_left     = 8'd0;
            skip_left    = 8'd0;
            if (budget_left == 16'd0)
            begin
                ph = PH_DONE;
                burst.push_back(make_result('0, 4'd0, 1'b1));
            end
            else
                ph = PH_HEADER;
        end
        else if (it.action == ACT_END)
        begin
            if (stream_open())
            begin
                used = 1'b1;
                ph = PH_DONE;
                lit_left  = 8'd0;
                skip_left = 8'd0;
                burst.push_back(make_result('0, 4'd0, 1'b1));
            end
        end
        else if (it.action == ACT_DATA && stream_open())
        begin
            used = 1'b1;
            case (ph)
                PH_HEADER:
                begin
                    if (b <= LIT_MAX_HDR)
                    begin
                        copy_len  = {1'b0, b} + 9'd1;
                        lit_left  = ({7'd0, copy_len} < budget_left) ? copy_len[7:0]
                                                                    : budget_left[7:0];
                        skip_left = copy_len[7:0] - lit_left;
                        ph = (lit_left != 8'd0) ? PH_LITERAL : PH_SKIP;
                    end
                    else if (b > NOP_HDR)
                    begin
                        lit_left = 8'(RUN_BASE - {1'b0, b});
                        ph = PH_REPVAL;
                    end
                end
                PH_LITERAL:
                begin
                    lit_left     = lit_left - 8'd1;
                    budget_left  = budget_left - 16'd1;
                    produced_cnt = produced_cnt + 16'd1;
                    if (lit_left == 8'd0)
                        end_of_copy();
                    burst.push_back(make_result({56'd0, b}, 4'd1, ph == PH_DONE));
                end
                PH_REPVAL:
                begin
                    rem = ({8'd0, lit_left} < budget_left) ? {8'd0, lit_left} : budget_left;
                    lit_left    = 8'd0;
                    budget_left = budget_left - rem;
                    ph = (budget_left == 16'd0) ? PH_DONE : PH_HEADER;
                    while (rem != 16'd0)
                    begin
                        c = (rem < 16'(LANES)) ? rem[3:0] : 4'(LANES);
                        d = '0;
                        for (int i = 0; i < int'(c); i++)
                            d[8*i +: 8] = b;
                        rem = rem - {12'd0, c};
                        produced_cnt = produced_cnt + {12'd0, c};
                        burst.push_back(make_result(d, c, rem == 16'd0 && ph == PH_DONE));
                    end
                end
                default:
                begin
                    skip_left = skip_left - 8'd1;
                    if (skip_left == 8'd0)
                    begin
                        end_of_copy();
                        if (ph == PH_DONE)
                            burst.push_back(make_result('0, 4'd0, 1'b1));
                    end
                end
            endcase
        end
        if (burst.size() != 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            due_results.push_back(burst[i]);
        return used;
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [7:0] b);
        int r;
        int gap;
        item_t it;
        gap = 0;
        if (tx_gaps)
        begin
            r = $urandom_range(0, 99);
            if (r >= 90)
                gap = $urandom_range(6, 30);
            else if (r >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        it.action    = act;
        it.data_byte = b;
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        if (decode_item(it))
            decoded_items++;
    endtask

    // block must be idle before a register write
    task automatic settle_idle();
        @(negedge clk);
        push <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_request_length(input logic [15:0] v);
        settle_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        req_len = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic note_failure(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    // result side: random pop stalls
    initial
    begin
        pop = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (!rx_stalls)
                pop <= 1'b1;
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4:
                    begin
                        pop <= 1'b0;
                        stall_left = $urandom_range(0, 3);
                    end
                    5:
                    begin
                        pop <= 1'b0;
                        stall_left = $urandom_range(10, 40);
                    end
                    default:
                        pop <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (due_results.size() == 0)
                note_failure("result transaction with nothing due", '0, result.data);
            else
            begin
                head = due_results.pop_front();
                if (result.data !== head.data)
                    note_failure("data", head.data, result.data);
                if (result.byte_count !== head.byte_count)
                    note_failure("byte_count", 64'(head.byte_count), 64'(result.byte_count));
                if (result.last !== head.last)
                    note_failure("last", 64'(head.last), 64'(result.last));
                if (result.done_res !== head.done_res)
                    note_failure("done_res", 64'(head.done_res), 64'(result.done_res));
                if (result.produced !== head.produced)
                    note_failure("produced", 64'(head.produced), 64'(result.produced));
            end
        end
    end

    task automatic test_ignored_items();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        send_item(ACT_DATA, 8'h55);
        send_item(ACT_END, 8'h00);
        send_item(ACT_UNUSED, 8'hAA);
    endtask

    task automatic test_reset_length();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_item(ACT_START, 8'h00);
        send_item(ACT_DATA, NOP_HDR);
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'hA5);
        send_item(ACT_DATA, 8'h81);
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'h12);
    endtask

    task automatic test_short_lengths();
        set_request_length(16'd0);
        send_item(ACT_START, 8'h00);
        set_request_length(16'd1);
        send_item(ACT_START, 8'h00);
        send_item(ACT_DATA, 8'h81);
        send_item(ACT_DATA, 8'h3C);
    endtask

    task automatic test_literal_skip_and_restart();
        tx_gaps = 1'b0;
        set_request_length(16'd2);
        send_item(ACT_START, 8'h00);
        send_item(ACT_DATA, 8'h02);
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_DATA, 8'h7F);
        send_item(ACT_START, 8'h00);
        send_item(ACT_DATA, 8'h85);
        send_item(ACT_START, 8'h00);
        send_item(ACT_END, 8'h00);
    endtask

    task automatic test_longest_run();
        rx_stalls = 1'b1;
        set_request_length(16'hFFFF);
        send_item(ACT_START, 8'h00);
        send_item(ACT_DATA, 8'h81);
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_END, 8'h00);
    endtask

    task automatic test_random_streams();
        int target;
        int per_req;
        int n;
        logic [15:0] len;
        target = decoded_items + RANDOM_ITEMS;
        while (decoded_items < target)
        begin
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 9))
                    0: len = 16'd1;
                    1: len = 16'hFFFF;
                    2: len = 16'd0;
                    3: len = 16'($urandom_range(0, 65535));
                    default: len = 16'($urandom_range(2, 60));
                endcase
                set_request_length(len);
            end
            send_item(ACT_START, 8'($urandom));
            per_req = 0;
            while (stream_open() && per_req < 25 && decoded_items < target)
            begin
                n = $urandom_range(0, 99);
                if (n < 45)
                begin
                    n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 127)
                                                     : $urandom_range(0, 7);
                    send_item(ACT_DATA, 8'(n));
                    while (ph == PH_LITERAL || ph == PH_SKIP)
                        send_item(ACT_DATA, 8'($urandom));
                end
                else if (n < 80)
                begin
                    send_item(ACT_DATA, 8'($urandom_range(129, 255)));
                    if (ph == PH_REPVAL)
                        send_item(ACT_DATA, 8'($urandom));
                end
                else if (n < 85)
                    send_item(ACT_DATA, NOP_HDR);
                else if (n < 90)
                    send_item(2'($urandom_range(0, 3)), 8'($urandom));
                else if (n < 93)
                    send_item(ACT_END, 8'($urandom));
                else
                    send_item(ACT_DATA, 8'($urandom));
                per_req++;
            end
            if (stream_open() && $urandom_range(0, 1) == 1)
                send_item(ACT_END, 8'($urandom));
        end
    endtask

    initial
    begin
        int spin;
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        mismatches    = 0;
        decoded_items = 0;
        req_len      = REQ_LEN_RESET;
        ph           = PH_IDLE;
        lit_left     = '0;
        skip_left    = '0;
        budget_left  = '0;
        produced_cnt = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ignored_items();
        test_reset_length();
        test_short_lengths();
        test_literal_skip_and_restart();
        test_longest_run();
        test_random_streams();

        @(negedge clk);
        push <= 1'b0;
        for (spin = 0; spin < DRAIN_LIMIT && due_results.size() != 0; spin++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
src/pkbd_pkg.sv
src/pkbd_front.sv
src/pkbd_cmd_fifo.sv
src/pkbd_back.sv
src/packbits_run_length_decoder.sv
test/packbits_run_length_decoder_tb.sv
